// ===== hdl/dlr_pkg.sv =====
// dlr_pkg: shared constants and types for the DDA line rasteriser.
// Used by the channel interfaces, the front end, the queue, the back end and the top level.
package dlr_pkg;

	localparam int REG_W      = 13;
	localparam int INDEX_W    = 24;
	localparam int COLOUR_W   = 32;
	localparam int IN_COORD_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 2'd2;

	localparam logic [REG_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [REG_W-1:0] RST_ROW_STRIDE    = 13'd640;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== hdl/dlr_in_if.sv =====
// dlr_in_if: input word channel (valid/ready) carrying one start or advance word.
// Depends on dlr_pkg for field widths.
interface dlr_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic signed [dlr_pkg::IN_COORD_W-1:0] x_start;
	logic signed [dlr_pkg::IN_COORD_W-1:0] y_start;
	logic signed [dlr_pkg::IN_COORD_W-1:0] x_end;
	logic signed [dlr_pkg::IN_COORD_W-1:0] y_end;
	logic        [dlr_pkg::COLOUR_W-1:0]   pixel_value;

	modport source (output valid, op, x_start, y_start, x_end, y_end, pixel_value,
		input ready);
	modport sink (input valid, op, x_start, y_start, x_end, y_end, pixel_value,
		output ready);
endinterface

// ===== hdl/dlr_out_if.sv =====
// dlr_out_if: result word channel (valid/ready) carrying one pixel write.
// Depends on dlr_pkg for field widths.
interface dlr_out_if;
	logic                           valid;
	logic                           ready;
	logic                           write_enable;
	logic [dlr_pkg::INDEX_W-1:0]    pixel_index;
	logic [dlr_pkg::COLOUR_W-1:0]   pixel_colour;
	logic                           last;

	modport source (output valid, write_enable, pixel_index, pixel_colour, last,
		input ready);
	modport sink (input valid, write_enable, pixel_index, pixel_colour, last,
		output ready);
endinterface

// ===== hdl/dlr_front.sv =====
// dlr_front: accepts input words, truncates coordinates, forms deltas, magnitudes and step.
// Depends on dlr_pkg and dlr_in_if; pushes packed entries into the command queue.
module dlr_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	dlr_in_if.sink              in_ch,
	input  dlr_pkg::q_stat_t    q_stat,
	output logic                q_push,
	output logic [3*(COORD_BITS+1)+2*COORD_BITS+dlr_pkg::COLOUR_W+2:0] q_wdata
);
	localparam int C    = COORD_BITS;
	localparam int DW   = C + 1;
	localparam int IN_W = (C > dlr_pkg::IN_COORD_W) ? C : dlr_pkg::IN_COORD_W;

	logic signed [IN_W-1:0] xs_ext, ys_ext, xe_ext, ye_ext;
	logic        [C-1:0]    x1, y1, x2, y2;
	logic                   in_ready;

	logic                          v_s1;
	logic                          op_s1;
	logic [C-1:0]                  x1_s1, y1_s1;
	logic [DW-1:0]                 dx_s1, dy_s1;
	logic [dlr_pkg::COLOUR_W-1:0]  colour_s1;

	logic [DW-1:0] mx, my, stp;

	assign xs_ext = IN_W'(in_ch.x_start);
	assign ys_ext = IN_W'(in_ch.y_start);
	assign xe_ext = IN_W'(in_ch.x_end);
	assign ye_ext = IN_W'(in_ch.y_end);
	assign x1 = xs_ext[C-1:0];
	assign y1 = ys_ext[C-1:0];
	assign x2 = xe_ext[C-1:0];
	assign y2 = ye_ext[C-1:0];

	assign q_push   = v_s1 && !q_stat.full;
	assign in_ready = !v_s1 || !q_stat.full;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			op_s1     <= dlr_pkg::OP_START;
			x1_s1     <= '0;
			y1_s1     <= '0;
			dx_s1     <= '0;
			dy_s1     <= '0;
			colour_s1 <= '0;
		end else if (in_ready) begin
			v_s1 <= in_ch.valid;
			if (in_ch.valid) begin
				op_s1     <= in_ch.op;
				x1_s1     <= x1;
				y1_s1     <= y1;
				dx_s1     <= {x2[C-1], x2} - {x1[C-1], x1};
				dy_s1     <= {y2[C-1], y2} - {y1[C-1], y1};
				colour_s1 <= in_ch.pixel_value;
			end
		end
	end

	// magnitudes and major-axis length
	assign mx  = dx_s1[C] ? (~dx_s1 + DW'(1)) : dx_s1;
	assign my  = dy_s1[C] ? (~dy_s1 + DW'(1)) : dy_s1;
	assign stp = (mx >= my) ? mx : my;

	assign q_wdata = {op_s1, dx_s1[C], dy_s1[C], mx, my, stp, x1_s1, y1_s1, colour_s1};

endmodule

// ===== hdl/dlr_fifo.sv =====
// dlr_fifo: short register queue between front and back ends.
// Depends on dlr_pkg for the status struct.
module dlr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              pop,
	output logic [WIDTH-1:0]  rdata,
	output dlr_pkg::q_stat_t  stat
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== hdl/dlr_back.sv =====
// dlr_back: executes queued words: restoring divider for increments, DDA stepping,
// clipping and a two-stage index pipeline ending in the output register.
// Depends on dlr_pkg and dlr_out_if.
module dlr_back #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dlr_pkg::q_stat_t                q_stat,
	input  logic [3*(COORD_BITS+1)+2*COORD_BITS+dlr_pkg::COLOUR_W+2:0] q_rdata,
	output logic                            q_pop,
	input  logic [dlr_pkg::REG_W-1:0]       screen_width,
	input  logic [dlr_pkg::REG_W-1:0]       screen_height,
	input  logic [dlr_pkg::REG_W-1:0]       row_stride,
	dlr_out_if.source                       out_ch
);
	localparam int C     = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int DW    = C + 1;
	localparam int RW    = C + 2;
	localparam int POS_W = C + F + 1;
	localparam int INC_W = F + 2;
	localparam int CNT_W = $clog2(F + 1);
	localparam int CMP_W = (C > dlr_pkg::REG_W) ? C : dlr_pkg::REG_W;
	localparam int PRD_W = C + dlr_pkg::REG_W;
	localparam int SUM_W = PRD_W + 1;

	typedef enum logic {ST_RUN, ST_DIV} state_t;

	logic                         e_op, e_sx, e_sy;
	logic [DW-1:0]                e_mx, e_my, e_step;
	logic [C-1:0]                 e_x1, e_y1;
	logic [dlr_pkg::COLOUR_W-1:0] e_colour;

	assign {e_op, e_sx, e_sy, e_mx, e_my, e_step, e_x1, e_y1, e_colour} = q_rdata;

	state_t                       state_q;
	logic signed [POS_W-1:0]      x_pos_q, y_pos_q;
	logic signed [INC_W-1:0]      x_inc_q, y_inc_q;
	logic [DW-1:0]                steps_q;
	logic [dlr_pkg::COLOUR_W-1:0] colour_q;

	logic [RW-1:0]                rem_x_q, rem_y_q;
	logic [DW-1:0]                dstep_q;
	logic [F:0]                   qx_q, qy_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         sx_q, sy_q;

	logic                         v_s1, we_s1, last_s1;
	logic [C-1:0]                 row_s1, col_s1;
	logic [dlr_pkg::COLOUR_W-1:0] colour_s1;

	logic                         out_valid_q, we_q, last_q;
	logic [dlr_pkg::INDEX_W-1:0]  index_q;
	logic [dlr_pkg::COLOUR_W-1:0] out_colour_q;

	logic s2_free, s1_free, pop_adv, pop_start;

	// divider datapath
	logic [RW-1:0]           dstep_ext, rx, ry;
	logic                    bx, by;
	logic [F:0]              qx_next, qy_next;
	logic signed [INC_W-1:0] qx_ext, qy_ext;

	// stepping datapath
	logic [C:0]       col_full, row_full;
	logic             on_screen;

	// index datapath
	logic [PRD_W-1:0] prod;
	logic [SUM_W-1:0] sum;

	assign s2_free   = !out_valid_q || out_ch.ready;
	assign s1_free   = !v_s1 || s2_free;
	assign pop_start = !q_stat.empty && (state_q == ST_RUN) && (e_op == dlr_pkg::OP_START);
	assign pop_adv   = !q_stat.empty && (state_q == ST_RUN) && (e_op == dlr_pkg::OP_ADVANCE)
		&& s1_free;
	assign q_pop     = pop_start || pop_adv;

	assign dstep_ext = {1'b0, dstep_q};
	assign bx = (rem_x_q >= dstep_ext);
	assign by = (rem_y_q >= dstep_ext);
	assign rx = bx ? (rem_x_q - dstep_ext) : rem_x_q;
	assign ry = by ? (rem_y_q - dstep_ext) : rem_y_q;
	assign qx_next = {qx_q[F-1:0], bx};
	assign qy_next = {qy_q[F-1:0], by};
	assign qx_ext = {1'b0, qx_next};
	assign qy_ext = {1'b0, qy_next};

	assign col_full = x_pos_q[POS_W-1:F];
	assign row_full = y_pos_q[POS_W-1:F];
	assign on_screen = !col_full[C] && !row_full[C]
		&& (CMP_W'(col_full[C-1:0]) < CMP_W'(screen_width))
		&& (CMP_W'(row_full[C-1:0]) < CMP_W'(screen_height));

	assign prod = PRD_W'(row_s1) * PRD_W'(row_stride);
	assign sum  = SUM_W'(prod) + SUM_W'(col_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			x_pos_q      <= '0;
			y_pos_q      <= '0;
			x_inc_q      <= '0;
			y_inc_q      <= '0;
			steps_q      <= '0;
			colour_q     <= '0;
			rem_x_q      <= '0;
			rem_y_q      <= '0;
			dstep_q      <= '0;
			qx_q         <= '0;
			qy_q         <= '0;
			cnt_q        <= '0;
			sx_q         <= 1'b0;
			sy_q         <= 1'b0;
			v_s1         <= 1'b0;
			we_s1        <= 1'b0;
			last_s1      <= 1'b0;
			row_s1       <= '0;
			col_s1       <= '0;
			colour_s1    <= '0;
			out_valid_q  <= 1'b0;
			we_q         <= 1'b0;
			last_q       <= 1'b0;
			index_q      <= '0;
			out_colour_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (pop_start) begin
						colour_q <= e_colour;
						x_pos_q  <= {e_x1[C-1], e_x1, {F{1'b0}}};
						y_pos_q  <= {e_y1[C-1], e_y1, {F{1'b0}}};
						x_inc_q  <= '0;
						y_inc_q  <= '0;
						steps_q  <= e_step;
						rem_x_q  <= RW'(e_mx);
						rem_y_q  <= RW'(e_my);
						dstep_q  <= e_step;
						sx_q     <= e_sx;
						sy_q     <= e_sy;
						qx_q     <= '0;
						qy_q     <= '0;
						cnt_q    <= '0;
						if (e_step != '0)
							state_q <= ST_DIV;
					end else if (pop_adv && steps_q != '0) begin
						x_pos_q <= x_pos_q + POS_W'(x_inc_q);
						y_pos_q <= y_pos_q + POS_W'(y_inc_q);
						steps_q <= steps_q - DW'(1);
					end
				end
				ST_DIV: begin
					rem_x_q <= {rx[RW-2:0], 1'b0};
					rem_y_q <= {ry[RW-2:0], 1'b0};
					qx_q    <= qx_next;
					qy_q    <= qy_next;
					cnt_q   <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(F)) begin
						x_inc_q <= sx_q ? -qx_ext : qx_ext;
						y_inc_q <= sy_q ? -qy_ext : qy_ext;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			// stage 1: clip and split the current point
			if (s1_free) begin
				v_s1 <= pop_adv;
				if (pop_adv) begin
					we_s1     <= (steps_q != '0) && on_screen;
					last_s1   <= (steps_q == '0) || (steps_q == DW'(1));
					row_s1    <= row_full[C-1:0];
					col_s1    <= col_full[C-1:0];
					colour_s1 <= colour_q;
				end
			end

			// stage 2: linear index into the output register
			if (s2_free) begin
				out_valid_q <= v_s1;
				if (v_s1) begin
					we_q         <= we_s1;
					last_q       <= last_s1;
					index_q      <= we_s1 ? sum[dlr_pkg::INDEX_W-1:0] : '0;
					out_colour_q <= colour_s1;
				end
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.write_enable = we_q;
	assign out_ch.pixel_index  = index_q;
	assign out_ch.pixel_colour = out_colour_q;
	assign out_ch.last         = last_q;

endmodule

// ===== hdl/dda_line_rasterizer_core.sv =====
// dda_line_rasterizer_core: DDA line rasteriser, front end, command queue and back end.
// An advance word passes the front register, queue, back stage 1 and output register.
// Throughput: one advance word per cycle while the output is not stalled; a start word
// holds the back end while the restoring divider forms both increments.
// Reset: asynchronous, clears queue, pipeline and line state; registers to 640/480/640.
// Depends on dlr_pkg, dlr_in_if, dlr_out_if, dlr_front, dlr_fifo, dlr_back.
module dda_line_rasterizer_core #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_BITS  = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlr_pkg::REG_W-1:0]       cfg_data,
	dlr_in_if.sink                          in_ch,
	dlr_out_if.source                       out_ch
);
	localparam int Q_W = 3 * (COORD_BITS + 1) + 2 * COORD_BITS + dlr_pkg::COLOUR_W + 3;

	logic [dlr_pkg::REG_W-1:0] screen_width_q, screen_height_q, row_stride_q;
	dlr_pkg::q_stat_t          q_stat;
	logic                      q_push, q_pop;
	logic [Q_W-1:0]            q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= dlr_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= dlr_pkg::RST_SCREEN_HEIGHT;
			row_stride_q    <= dlr_pkg::RST_ROW_STRIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				dlr_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				dlr_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				dlr_pkg::REG_ROW_STRIDE:    row_stride_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	dlr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	dlr_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	dlr_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.row_stride    (row_stride_q),
		.out_ch        (out_ch)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue pushed while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("queue popped while empty");

	a_cfg_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index > dlr_pkg::REG_ROW_STRIDE) |=>
		screen_width_q == $past(screen_width_q) && screen_height_q == $past(screen_height_q)
		&& row_stride_q == $past(row_stride_q))
		else $error("write beyond register list changed a register");

endmodule
